// ===== sv/power_to_bcd_float_encoder_assert.svh =====
// Assertion macros shared by the checker of the power to BCD float encoder.
// Depends on: nothing; the including scope provides aclk and aresetn.
`ifndef POWER_TO_BCD_FLOAT_ENCODER_ASSERT_SVH
`define POWER_TO_BCD_FLOAT_ENCODER_ASSERT_SVH

// Checked only while out of reset.
`define PBF_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PBF_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/pbf_pkg.sv =====
// Types and constants of the power to BCD float encoder.
// Depends on: nothing.
package pbf_pkg;

    localparam int unsigned IN_W       = 32;
    localparam int unsigned OUT_W      = 16;
    localparam int unsigned MANT_W     = 10;
    localparam int unsigned EXP_W      = 3;
    localparam int unsigned DIV_STEPS  = 6;

    localparam logic [IN_W-1:0]   MANT_LIMIT  = 32'd1000;
    localparam logic [MANT_W-1:0] MANT_MAX    = 10'd999;
    localparam logic [IN_W-1:0]   EXACT_LIMIT = 32'd99900;
    localparam logic [EXP_W-1:0]  EXACT_CODE  = 3'd4;
    localparam logic [EXP_W-1:0]  SAT_CODE    = 3'd0;
    localparam logic [3:0]        DIGIT_MAX   = 4'd9;

    // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v
    localparam logic [63:0]       RECIP_10    = 64'h0000_0000_CCCC_CCCD;
    localparam int unsigned       RECIP_SHIFT = 35;

    typedef struct packed {
        logic [IN_W-1:0]   val;        // magnitude, divided by 10 once per stage
        logic              neg;
        logic              below_lim;  // magnitude below the exact-hundreds limit
        logic              rnz;        // nonzero remainder in the first two divisions
        logic              exact;
        logic [MANT_W-1:0] emant;      // magnitude / 100 for the exact case
        logic              found;
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  code;
    } pbf_stage_t;

    // Three BCD digits of a value below 1000, by reciprocal multiplies.
    function automatic logic [11:0] bcd3(input logic [MANT_W-1:0] m);
        logic [15:0] ph;
        logic [3:0]  h;
        logic [9:0]  rem;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [7:0]  u;
        ph  = 16'(m) * 16'd41;
        h   = ph[15:12];
        rem = m - (10'(h) * 10'd100);
        pt  = 15'(rem[6:0]) * 15'd205;
        t   = pt[14:11];
        u   = 8'(rem[6:0]) - (8'(t) * 8'd10);
        return {h, t, u[3:0]};
    endfunction

endpackage

// ===== sv/pbf_abs.sv =====
// Input stage: sign split and magnitude of the power value.
// Depends on: pbf_pkg.
module pbf_abs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [pbf_pkg::IN_W-1:0]  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output pbf_pkg::pbf_stage_t       out_data
);
    import pbf_pkg::*;

    logic       valid_reg;
    pbf_stage_t data_reg;
    pbf_stage_t data_next;
    logic       neg;

    assign in_ready = !valid_reg || out_ready;
    assign neg      = in_data[IN_W-1];

    always_comb begin
        data_next       = '0;
        data_next.neg   = neg;
        data_next.val   = neg ? (IN_W'(0) - in_data) : in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== sv/pbf_div10_stage.sv =====
// One divide-by-ten stage; records the mantissa once the value drops below 1000.
// Depends on: pbf_pkg.
module pbf_div10_stage #(
    parameter int unsigned STEP = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  pbf_pkg::pbf_stage_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pbf_pkg::pbf_stage_t out_data
);
    import pbf_pkg::*;

    logic       valid_reg;
    pbf_stage_t data_reg;
    pbf_stage_t data_next;
    logic [63:0]     prod;
    logic [IN_W-1:0] quot;
    logic [IN_W-1:0] back;

    assign in_ready = !valid_reg || out_ready;

    assign prod = 64'(in_data.val) * RECIP_10;
    assign quot = IN_W'(prod >> RECIP_SHIFT);
    assign back = (quot << 3) + (quot << 1);

    always_comb begin
        data_next     = in_data;
        data_next.val = quot;
        // step count so far is STEP-1; the code is that count plus one, inverted
        if (!in_data.found && (in_data.val < MANT_LIMIT)) begin
            data_next.found = 1'b1;
            data_next.mant  = in_data.val[MANT_W-1:0];
            data_next.code  = ~EXP_W'(STEP);
        end
        if (STEP == 1) begin
            data_next.below_lim = in_data.val < EXACT_LIMIT;
        end
        if (STEP <= 2) begin
            data_next.rnz = in_data.rnz || (back != in_data.val);
        end
        if (STEP == 2) begin
            data_next.exact = in_data.below_lim && !data_next.rnz;
            data_next.emant = quot[MANT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

// ===== sv/pbf_bcd_out.sv =====
// Output stage: mantissa selection, saturation, BCD digits and word assembly.
// Depends on: pbf_pkg.
module pbf_bcd_out (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  pbf_pkg::pbf_stage_t       in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [pbf_pkg::OUT_W-1:0] out_data
);
    import pbf_pkg::*;

    logic              valid_reg;
    logic [OUT_W-1:0]  word_reg;
    logic [OUT_W-1:0]  word_next;
    logic [MANT_W-1:0] mant;
    logic [EXP_W-1:0]  code;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        if (in_data.exact) begin
            mant = in_data.emant;
            code = EXACT_CODE;
        end else if (in_data.found) begin
            mant = in_data.mant;
            code = in_data.code;
        end else begin
            // all six divisions taken
            mant = (in_data.val < MANT_LIMIT) ? in_data.val[MANT_W-1:0] : MANT_MAX;
            code = SAT_CODE;
        end
        word_next = {code, in_data.neg, bcd3(mant)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;
endmodule

// ===== sv/power_to_bcd_float_encoder.sv =====
// Pipeline: 8 register stages; one 32x32 reciprocal multiply in each divide stage.
// Throughput: one item per cycle while m_tready does not stall the output.
// Each stage holds its item until the next takes it, so bubbles close up under stall.
// Reset: synchronous, active-low aresetn clears every stage valid bit.
// Depends on: pbf_pkg, pbf_abs, pbf_div10_stage, pbf_bcd_out.
module power_to_bcd_float_encoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pbf_pkg::IN_W-1:0]  s_tdata,   // [31:0] power_value
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pbf_pkg::OUT_W-1:0] m_tdata    // [15:0] encoded_word
);
    import pbf_pkg::*;

    // stage k feeds stage k+1; index 0 is the magnitude stage
    logic       vld [DIV_STEPS+1];
    logic       rdy [DIV_STEPS+1];
    pbf_stage_t dat [DIV_STEPS+1];

    pbf_abs u_abs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (dat[0])
    );

    // Each divide stage divides by ten unconditionally; the first stage whose
    // input is already below 1000 latches mantissa and exponent code.
    // Stages one and two also track the remainder for the exact-hundreds case.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        pbf_div10_stage #(
            .STEP (g + 1)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_data   (dat[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_data  (dat[g+1])
        );
    end

    // Exact case wins; otherwise a value still not found keeps its quotient, capped at 999.
    pbf_bcd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[DIV_STEPS]),
        .in_ready  (rdy[DIV_STEPS]),
        .in_data   (dat[DIV_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );
endmodule

// ===== sv/pbf_assert_checker.sv =====
// Port-level checks of the power to BCD float encoder, bound to the top level.
// Depends on: pbf_pkg, power_to_bcd_float_encoder_assert.svh.
`include "power_to_bcd_float_encoder_assert.svh"

module pbf_assert_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [pbf_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [pbf_pkg::OUT_W-1:0] m_tdata
);
    import pbf_pkg::*;

    `PBF_ASSERT_ALL(a_reset_empties, !aresetn |=> !m_tvalid, "result valid after reset")

    `PBF_ASSERT_RUN(a_hold_on_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `PBF_ASSERT_RUN(a_bcd_digits, m_tvalid |-> (m_tdata[11:8] <= DIGIT_MAX) && (m_tdata[7:4] <= DIGIT_MAX) && (m_tdata[3:0] <= DIGIT_MAX), "mantissa digit out of BCD range")

    `PBF_ASSERT_RUN(a_code_range, m_tvalid |-> m_tdata[15:13] != '1, "exponent code never reachable")

endmodule

bind power_to_bcd_float_encoder pbf_assert_checker u_pbf_assert_checker (.*);
